// ===== rtl/rgb_contrast_stretch_macros.svh =====
// Assertion helpers used by rtl/rgb_contrast_stretch.sv.
`ifndef RGB_CONTRAST_STRETCH_MACROS_SVH
`define RGB_CONTRAST_STRETCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcs_pkg.sv =====
package rcs_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DIV_STEPS  = PIX_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CLEAR   = 2'd0;
  localparam cmd_t CMD_MEASURE = 2'd1;
  localparam cmd_t CMD_MAP     = 2'd2;

  localparam pix_t PIX_MAX  = '1;
  localparam pix_t PIX_ZERO = '0;

  // Control from the sequencer to each channel divider.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== rtl/rcs_divider.sv =====
// One channel: stretch setup on load, then one restoring-division quotient
// bit per step. Special cases (flat range, at/below low, quotient >= 256)
// are settled at load and held.
module rcs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcs_pkg::div_ctrl_t ctrl_i,
  input  rcs_pkg::pix_t     value_i,
  input  rcs_pkg::pix_t     low_i,
  input  rcs_pkg::pix_t     high_i,
  output rcs_pkg::pix_t     result_o
);
  import rcs_pkg::*;

  pix_t                 rem_q, rem_d;
  pix_t                 num_q, num_d;
  pix_t                 den_q, den_d;
  pix_t                 quo_q, quo_d;
  logic                 hold_q, hold_d;

  logic                 flat, under, over;
  pix_t                 diff, span;
  logic [2*PIX_W-1:0]   scaled;
  logic [PIX_W:0]       trial;
  logic [PIX_W:0]       trial_sub;
  logic                 bit_one;

  // (v - lo) * 255 as (d << 8) - d
  always_comb begin
    flat   = (high_i <= low_i);
    under  = (value_i <= low_i);
    diff   = value_i - low_i;
    span   = high_i - low_i;
    scaled = {diff, PIX_ZERO} - {PIX_ZERO, diff};
    over   = (scaled[2*PIX_W-1:PIX_W] >= span);
  end

  always_comb begin
    trial     = {rem_q, num_q[PIX_W-1]};
    trial_sub = trial - {1'b0, den_q};
    bit_one   = (trial >= {1'b0, den_q});
  end

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    hold_d = hold_q;
    if (ctrl_i.load) begin
      rem_d  = scaled[2*PIX_W-1:PIX_W];
      num_d  = scaled[PIX_W-1:0];
      den_d  = span;
      hold_d = flat || under || over;
      priority if (flat) begin
        quo_d = value_i;
      end else if (under) begin
        quo_d = PIX_ZERO;
      end else if (over) begin
        quo_d = PIX_MAX;
      end else begin
        quo_d = PIX_ZERO;
      end
    end else if (ctrl_i.step && !hold_q) begin
      rem_d = bit_one ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
      num_d = {num_q[PIX_W-2:0], 1'b0};
      quo_d = {quo_q[PIX_W-2:0], bit_one};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b1;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign result_o = quo_q;

endmodule

// ===== rtl/rgb_contrast_stretch.sv =====
// Channel  Direction  Handshake             Payload
// in       request    in_valid_i/in_stall_o command_i, red_in_i, green_in_i, blue_in_i
// out      result     out_valid_o/out_stall_i red_out_o, green_out_o, blue_out_o
//
// Clear and measure requests give no result, and the block stays ready for the next request.
// A map request holds off the next one until its pixel is handed off: a load,
//   then 8 quotient-bit steps in three side-by-side channel dividers, a handoff.
// Reset (rst_ni, async, low) sets every low to 255 and every high to 0.
// A finished pixel waits in the output register; requests keep coming in
//   meanwhile, and only the handoff waits on out_stall_i.
module rgb_contrast_stretch (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rcs_pkg::cmd_t command_i,
  input  rcs_pkg::pix_t red_in_i,
  input  rcs_pkg::pix_t green_in_i,
  input  rcs_pkg::pix_t blue_in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rcs_pkg::pix_t red_out_o,
  output rcs_pkg::pix_t green_out_o,
  output rcs_pkg::pix_t blue_out_o
);
  import rcs_pkg::*;
`include "rgb_contrast_stretch_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  pix_t             red_out_q, green_out_q, blue_out_q;

  // running channel statistics
  pix_t red_lo_q, red_hi_q;
  pix_t grn_lo_q, grn_hi_q;
  pix_t blu_lo_q, blu_hi_q;

  logic      in_accept;
  logic      out_free;
  div_ctrl_t div_ctrl;
  pix_t      red_res, grn_res, blu_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // output register empty, or its pixel is leaving this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  assign div_ctrl.load = in_accept && (command_i == CMD_MAP);
  assign div_ctrl.step = (state_q == ST_DIV);

  rcs_divider u_div_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (red_in_i),
    .low_i   (red_lo_q),
    .high_i  (red_hi_q),
    .result_o(red_res)
  );

  rcs_divider u_div_grn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (green_in_i),
    .low_i   (grn_lo_q),
    .high_i  (grn_hi_q),
    .result_o(grn_res)
  );

  rcs_divider u_div_blu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (blue_in_i),
    .low_i   (blu_lo_q),
    .high_i  (blu_hi_q),
    .result_o(blu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      red_out_q   <= PIX_ZERO;
      green_out_q <= PIX_ZERO;
      blue_out_q  <= PIX_ZERO;
      red_lo_q    <= PIX_MAX;
      red_hi_q    <= PIX_ZERO;
      grn_lo_q    <= PIX_MAX;
      grn_hi_q    <= PIX_ZERO;
      blu_lo_q    <= PIX_MAX;
      blu_hi_q    <= PIX_ZERO;
    end else begin
      // a new pixel replaces one that leaves in the same cycle
      priority if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (command_i)
              CMD_CLEAR: begin
                red_lo_q <= PIX_MAX;
                red_hi_q <= PIX_ZERO;
                grn_lo_q <= PIX_MAX;
                grn_hi_q <= PIX_ZERO;
                blu_lo_q <= PIX_MAX;
                blu_hi_q <= PIX_ZERO;
              end
              CMD_MEASURE: begin
                if (red_in_i < red_lo_q)   red_lo_q <= red_in_i;
                if (red_in_i > red_hi_q)   red_hi_q <= red_in_i;
                if (green_in_i < grn_lo_q) grn_lo_q <= green_in_i;
                if (green_in_i > grn_hi_q) grn_hi_q <= green_in_i;
                if (blue_in_i < blu_lo_q)  blu_lo_q <= blue_in_i;
                if (blue_in_i > blu_hi_q)  blu_hi_q <= blue_in_i;
              end
              CMD_MAP: begin
                state_q <= ST_DIV;
                cnt_q   <= '0;
              end
              default: begin
                // unused code: dropped
              end
            endcase
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            red_out_q   <= red_res;
            green_out_q <= grn_res;
            blue_out_q  <= blu_res;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_out_q;
  assign green_out_o = green_out_q;
  assign blue_out_o  = blue_out_q;

  `RCS_ASSERT_NEXT(a_map_starts_div, in_accept && (command_i == CMD_MAP),
    state_q == ST_DIV, "map request did not start the dividers")
  `RCS_ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1)),
    state_q == ST_DONE, "divider did not finish after its last step")
  `RCS_ASSERT_SAME(a_out_from_done, $rose(out_valid_q),
    $past(state_q == ST_DONE), "result appeared without a finished division")
  `RCS_ASSERT_NEXT(a_measure_range, in_accept && (command_i == CMD_MEASURE),
    (red_lo_q <= red_hi_q) && (grn_lo_q <= grn_hi_q) && (blu_lo_q <= blu_hi_q),
    "channel range inverted after a measure")

endmodule

// ===== bench/rgb_contrast_stretch_tb.sv =====
`timescale 1ns / 1ps

// Two-pass contrast stretch: clear, measure to build per-channel ranges, then
// map. Random idling on the request side and stalls on the result side.
module rgb_contrast_stretch_tb;
  import rcs_pkg::*;

  // Command code 3 is unused; the block must drop it.
  localparam cmd_t        CMD_IGNORED     = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned CALM_AFTER      = 1400;  // no idling past this point
  localparam int unsigned DRAIN_CYCLES    = 40;    // idle clocks after the final drain

  // Pixels in the table are written as 24'hRRGGBB.
  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } pixel_t;

  typedef struct packed {
    cmd_t   cmd;
    pixel_t px;
    logic   typed;   // expected pixel given in the row
    pixel_t want;
  } stim_row_t;

  localparam pixel_t BLACK = '0;
  localparam pixel_t WHITE = '1;

  logic   clk_i;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  cmd_t   command_i   = CMD_CLEAR;
  pix_t   red_in_i    = '0;
  pix_t   green_in_i  = '0;
  pix_t   blue_in_i   = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  pix_t   red_out_o;
  pix_t   green_out_o;
  pix_t   blue_out_o;

  rgb_contrast_stretch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  // Predictor state: running low/high per channel (0 red, 1 green, 2 blue).
  pix_t range_low  [3];
  pix_t range_high [3];

  pixel_t      pending_pixels [$];   // stretched pixels still owed by the block
  stim_row_t   directed_rows  [$];
  int unsigned requests_done  = 0;
  int unsigned maps_done      = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatches     = 0;
  bit          quiet          = 1'b0;  // tail of the run: no idling on either side
  bit          gaps_on        = 1'b1;
  bit          stall_mode     = 1'b1;
  int unsigned stall_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case a request or a result never gets through.
  initial begin
    #20_000_000;
    $display("%0t ns: timeout, %0d pixels still owed", $time, pending_pixels.size());
    $display("Some tests failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // floor((v - lo) * 255 / (hi - lo)), clamped; flat range passes v through.
  function automatic pix_t stretch_value(pix_t v, pix_t lo, pix_t hi);
    int unsigned q;
    if (hi <= lo) return v;
    if (v <= lo) return PIX_ZERO;
    q = ((int'(v) - int'(lo)) * int'(PIX_MAX)) / (int'(hi) - int'(lo));
    if (q > PIX_MAX) q = PIX_MAX;
    return pix_t'(q);
  endfunction

  task automatic clear_ranges();
    for (int c = 0; c < 3; c++) begin
      range_low[c]  = PIX_MAX;
      range_high[c] = PIX_ZERO;
    end
  endtask

  // Applies one accepted request to the range state; a map yields a pixel.
  task automatic model_request(input cmd_t cmd, input pixel_t px,
                               output bit emits, output pixel_t res);
    pix_t v [3];
    pix_t o [3];
    v[0]  = px.red;
    v[1]  = px.green;
    v[2]  = px.blue;
    emits = 1'b0;
    res   = BLACK;
    case (cmd)
      CMD_CLEAR: clear_ranges();
      CMD_MEASURE: begin
        for (int c = 0; c < 3; c++) begin
          if (v[c] < range_low[c])  range_low[c]  = v[c];
          if (v[c] > range_high[c]) range_high[c] = v[c];
        end
      end
      CMD_MAP: begin
        for (int c = 0; c < 3; c++) o[c] = stretch_value(v[c], range_low[c], range_high[c]);
        res.red   = o[0];
        res.green = o[1];
        res.blue  = o[2];
        emits     = 1'b1;
      end
      default: ;  // unused code: nothing happens
    endcase
  endtask

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------

  // Called right after clk_i rises. Optional idle burst, then hold the
  // request until the block takes it; the prediction is made at acceptance.
  task automatic send_request(input cmd_t cmd, input pixel_t px,
                              input bit typed, input pixel_t want);
    bit     emits;
    pixel_t stretched;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    model_request(cmd, px, emits, stretched);
    if (emits) begin
      pending_pixels.push_back(typed ? want : stretched);
      maps_done++;
    end
    if (cmd != CMD_IGNORED) requests_done++;
  endtask

  // Stop sending until every owed pixel has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic add_row(input cmd_t cmd, input pixel_t px,
                         input bit typed, input pixel_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.px    = px;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic pixel_t pick_pixel(pixel_t lo, pixel_t hi);
    pixel_t px;
    px.red   = pix_t'($urandom_range(hi.red, lo.red));
    px.green = pix_t'($urandom_range(hi.green, lo.green));
    px.blue  = pix_t'($urandom_range(hi.blue, lo.blue));
    return px;
  endfunction

  // Value window for one channel of a frame: full, flat, narrow or random.
  task automatic pick_window(output pix_t lo, output pix_t hi);
    pix_t a;
    pix_t b;
    a = pix_t'($urandom);
    b = pix_t'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        lo = PIX_ZERO;
        hi = PIX_MAX;
      end
      1: begin
        lo = a;
        hi = a;
      end
      2: begin
        lo = (a > 8'd247) ? 8'd247 : a;
        hi = lo + pix_t'($urandom_range(1, 8));
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
  endtask

  // One frame: usually a clear, some measures, then maps. Map pixels mostly
  // come from the measured window; the rest land anywhere to hit the clamps.
  task automatic random_frame();
    pixel_t      win_lo;
    pixel_t      win_hi;
    int unsigned n_measure;
    int unsigned n_map;
    pick_window(win_lo.red, win_hi.red);
    pick_window(win_lo.green, win_hi.green);
    pick_window(win_lo.blue, win_hi.blue);
    gaps_on   = ($urandom_range(0, 3) != 0);
    n_measure = $urandom_range(0, 12);
    n_map     = $urandom_range(1, 16);
    if ($urandom_range(0, 9) != 0) send_request(CMD_CLEAR, pick_pixel(BLACK, WHITE), 1'b0, BLACK);
    repeat (n_measure) send_request(CMD_MEASURE, pick_pixel(win_lo, win_hi), 1'b0, BLACK);
    repeat (n_map) begin
      if ($urandom_range(0, 15) == 0)
        send_request(CMD_IGNORED, pick_pixel(BLACK, WHITE), 1'b0, BLACK);
      if ($urandom_range(0, 3) == 0)
        send_request(CMD_MAP, pick_pixel(BLACK, WHITE), 1'b0, BLACK);
      else
        send_request(CMD_MAP, pick_pixel(win_lo, win_hi), 1'b0, BLACK);
    end
  endtask

  // ------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------

  // Random stall bursts; stall_mode flips now and then so long
  // stretches run with no stall at all.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      stall_mode  <= 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) stall_mode <= !stall_mode;
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (stall_mode && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 17);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input pix_t want, input pix_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    pixel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: result with no map request owed, got %02h %02h %02h",
                 $time, red_out_o, green_out_o, blue_out_o);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("red", want.red, red_out_o);
        check_field("green", want.green, green_out_o);
        check_field("blue", want.blue, blue_out_o);
        pixels_checked++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  initial begin
    int unsigned start_count;

    // After reset every range is flat (high 0 < low 255): maps pass through.
    add_row(CMD_MAP,     24'h0080FF, 1'b1, 24'h0080FF);
    add_row(CMD_MAP,     24'hFF007F, 1'b1, 24'hFF007F);
    // Unused command: no result, state untouched.
    add_row(CMD_IGNORED, 24'h123456, 1'b0, BLACK);
    add_row(CMD_MAP,     24'hA5A5A5, 1'b1, 24'hA5A5A5);
    // Full 0..255 range measured: identity mapping.
    add_row(CMD_MEASURE, 24'h000000, 1'b0, BLACK);
    add_row(CMD_MEASURE, 24'hFFFFFF, 1'b0, BLACK);
    add_row(CMD_MAP,     24'h00FF80, 1'b1, 24'h00FF80);
    add_row(CMD_MAP,     24'h01FE7F, 1'b1, 24'h01FE7F);
    // Clear brings the flat range back.
    add_row(CMD_CLEAR,   24'hFFFFFF, 1'b0, BLACK);
    add_row(CMD_MAP,     24'h102030, 1'b1, 24'h102030);
    // A single measure gives low == high: still flat.
    add_row(CMD_MEASURE, 24'h404040, 1'b0, BLACK);
    add_row(CMD_MAP,     24'h4000FF, 1'b1, 24'h4000FF);
    // Ranges now 40..C0, 40..80, 40..60.
    add_row(CMD_MEASURE, 24'hC08060, 1'b0, BLACK);
    // Below low clamps to 0; at high and above high give full scale.
    add_row(CMD_MAP,     24'h2080FF, 1'b1, 24'h00FFFF);
    // Exactly at low maps to 0.
    add_row(CMD_MAP,     24'h404040, 1'b1, 24'h000000);
    add_row(CMD_MAP,     24'h807F50, 1'b0, BLACK);
    add_row(CMD_MAP,     24'hC0A055, 1'b0, BLACK);
    add_row(CMD_IGNORED, 24'hFFFFFF, 1'b0, BLACK);
    add_row(CMD_MAP,     24'hC0A055, 1'b0, BLACK);
    // One-step range 7F..80.
    add_row(CMD_CLEAR,   24'h000000, 1'b0, BLACK);
    add_row(CMD_MEASURE, 24'h7F7F7F, 1'b0, BLACK);
    add_row(CMD_MEASURE, 24'h808080, 1'b0, BLACK);
    add_row(CMD_MAP,     24'h7F80FF, 1'b1, 24'h00FFFF);
    add_row(CMD_MAP,     24'h00FF7F, 1'b1, 24'h00FF00);

    clear_ranges();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].px,
                   directed_rows[i].typed, directed_rows[i].want);

    // Hold off once until the directed pixels are all back.
    wait_for_drain();

    start_count = requests_done;
    while (requests_done - start_count < RANDOM_REQUESTS) begin
      quiet = (requests_done - start_count >= CALM_AFTER);
      if ($urandom_range(0, 7) == 0) begin
        // Noise: any command, any pixel, out of frame order.
        repeat ($urandom_range(1, 6))
          send_request(cmd_t'($urandom_range(0, 3)), pick_pixel(BLACK, WHITE), 1'b0, BLACK);
      end else begin
        random_frame();
      end
      if ($urandom_range(0, 24) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests, %0d of them maps, across clear/measure/map frames and noise.",
             requests_done, maps_done);
    $display("Compared %0d stretched pixels; %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
